// ----- rtl/lba_pkg.sv -----
// Shared types and constants of the lazy buddy allocator.
package lba_pkg;

   localparam logic [1:0] NODE_UNUSED = 2'd0;
   localparam logic [1:0] NODE_FREE   = 2'd1;
   localparam logic [1:0] NODE_SPLIT  = 2'd2;
   localparam logic [1:0] NODE_ALLOC  = 2'd3;

   localparam logic [1:0] STATUS_GRANTED = 2'd0;
   localparam logic [1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [1:0] STATUS_FREED   = 2'd2;
   localparam logic [1:0] STATUS_INVALID = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SPLIT,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_MERGE_RD,
      ST_MERGE_CHK,
      ST_XSCAN_RD,
      ST_XSCAN_CHK,
      ST_RESP
   } state_type;

endpackage

// ----- rtl/lazy_buddy_allocator_top.sv -----
// Lazy buddy allocator: block tree in a node memory, walked by one small sequencer.
//
// One request is in work at a time. Each node-memory read goes through a read state,
// then a check state. An allocate scans the nodes from the smallest level that fits
// up to the first free block and then splits it while the half still fits; a free
// walks down the tree levels and merges, and in lazy mode may scan the nodes of the
// freed level for an extra merge. No clearing pass: entries never written read as
// unused through one valid bit each, and the root is written free after reset, in a
// cycle with no other memory write.
module lazy_buddy_allocator_top
   import lba_pkg::*;
#(
   parameter int TOTAL_SIZE = 2048,
   parameter int MIN_BLOCK  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // operation
   input  logic [23:0] req_tdata,   // request_size[11:0], block_base[22:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // status[1:0], granted_base[12:2], granted_size[24:13]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   localparam int DEPTHS = $clog2(TOTAL_SIZE / MIN_BLOCK) + 1;
   localparam int NODES  = (1 << DEPTHS) - 1;
   localparam int IW     = $clog2(NODES + 1);
   localparam int DW     = $clog2(DEPTHS + 1);
   localparam int SW     = $clog2(TOTAL_SIZE) + 1;

   state_type state_ff, state_in;
   logic [1:0]  mem [NODES];
   logic [NODES-1:0] vld_ff;
   logic [7:0]  cnt_ff [DEPTHS];
   logic        mode_ff;
   logic        op_ff;
   logic [11:0] req_ff;
   logic [10:0] base_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic [DW-1:0] d_ff, d_in;
   logic [SW-1:0] k_ff, k_in;      // position within level, or node base
   logic [SW-1:0] sz_ff, sz_in;
   logic        split_ff, split_in;
   logic        xtra_ff, xtra_in;   // extra lazy merge pending
   logic [1:0]  rd_ff, bud_ff;
   logic [1:0]  status_ff, status_in;
   logic [10:0] obase_ff, obase_in;
   logic [11:0] osize_ff, osize_in;
   logic        rvalid_ff;

   // memory write ports and read addresses
   logic          we0, we1, we2;
   logic [IW-1:0] wa0, wa1, wa2;
   logic [1:0]    wd0, wd1, wd2;
   logic [IW-1:0] buddy;
   logic [IW-1:0] parent;
   logic [IW-1:0] lvl_first;
   logic [DW-1:0] lvl;
   logic          cnt_we;
   logic [7:0]    cnt_wd;
   logic [SW-1:0] req_ext;

   assign req_ext   = SW'(req_ff);
   assign buddy     = idx_ff[0] ? idx_ff + IW'(1) : idx_ff - IW'(1);
   assign parent    = IW'((idx_ff - IW'(1)) >> 1);
   assign lvl_first = IW'((1 << d_ff) - 1);
   assign lvl       = DW'(DEPTHS - 1) - d_ff;

   assign req_tready = (state_ff == ST_IDLE) && !rvalid_ff;
   assign csr_ready  = (state_ff == ST_IDLE) && !rvalid_ff;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {7'b0, osize_ff, obase_ff, status_ff};

   // node memory, read registered; unwritten entries read as unused
   always_ff @(posedge clock) begin
      if (we0) mem[wa0] <= wd0;
      if (we1) mem[wa1] <= wd1;
      if (we2) mem[wa2] <= wd2;
      rd_ff  <= vld_ff[idx_ff] ? mem[idx_ff] : NODE_UNUSED;
      bud_ff <= vld_ff[buddy] ? mem[buddy] : NODE_UNUSED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         vld_ff    <= '0;
         mode_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
         for (int i = 0; i < DEPTHS; i++) cnt_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (we0) vld_ff[wa0] <= 1'b1;
         if (we1) vld_ff[wa1] <= 1'b1;
         if (we2) vld_ff[wa2] <= 1'b1;
         if (csr_valid && csr_ready) mode_ff <= csr_data;
         if (cnt_we) cnt_ff[lvl] <= cnt_wd;
         if (state_ff == ST_RESP) rvalid_ff <= 1'b1;
         else if (rsp_tready) rvalid_ff <= 1'b0;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff   <= req_tuser;
         req_ff  <= req_tdata[11:0];
         base_ff <= req_tdata[22:12];
      end
      idx_ff   <= idx_in;
      d_ff     <= d_in;
      k_ff     <= k_in;
      sz_ff    <= sz_in;
      split_ff <= split_in;
      xtra_ff  <= xtra_in;
      status_ff <= status_in;
      obase_ff <= obase_in;
      osize_ff <= osize_in;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff; d_in = d_ff; k_in = k_ff; sz_in = sz_ff;
      split_in = split_ff; xtra_in = xtra_ff;
      status_in = status_ff; obase_in = obase_ff; osize_in = osize_ff;
      we0 = 1'b0; we1 = 1'b0; we2 = 1'b0;
      wa0 = idx_ff; wa1 = IW'(2 * idx_ff + 1); wa2 = IW'(2 * idx_ff + 2);
      wd0 = NODE_UNUSED; wd1 = NODE_FREE; wd2 = NODE_FREE;
      cnt_we = 1'b0; cnt_wd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               split_in = 1'b0; xtra_in = 1'b0;
               obase_in = '0; osize_in = '0;
               if (req_tuser == OP_ALLOC) begin
                  // start at the deepest level; the scan climbs until the block fits
                  d_in = DW'(DEPTHS - 1);
                  sz_in = SW'(TOTAL_SIZE >> (DEPTHS - 1));
                  k_in = '0;
                  idx_in = IW'(NODES / 2);
                  state_in = ST_SCAN_RD;
               end else begin
                  d_in = '0; k_in = '0; sz_in = SW'(TOTAL_SIZE); idx_in = '0;
                  state_in = ST_WALK_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            if (sz_ff < req_ext) begin
               if (d_ff == '0) begin
                  status_in = STATUS_NOSPACE; state_in = ST_RESP;
               end else begin
                  d_in = d_ff - DW'(1); sz_in = sz_ff << 1; k_in = '0;
                  idx_in = IW'((1 << (d_ff - DW'(1))) - 1);
               end
            end else state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (rd_ff == NODE_FREE) state_in = ST_SPLIT;
            else if (k_ff == SW'((1 << d_ff) - 1)) begin
               if (d_ff == '0) begin
                  status_in = STATUS_NOSPACE; state_in = ST_RESP;
               end else begin
                  d_in = d_ff - DW'(1); sz_in = sz_ff << 1; k_in = '0;
                  idx_in = IW'((1 << (d_ff - DW'(1))) - 1);
                  state_in = ST_SCAN_RD;
               end
            end else begin
               k_in = k_ff + SW'(1); idx_in = idx_ff + IW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SPLIT: begin
            // halve while the half fits and a deeper level exists; then grant
            if (d_ff != DW'(DEPTHS - 1) && (sz_ff >> 1) >= req_ext) begin
               we0 = 1'b1; wd0 = NODE_SPLIT; we1 = 1'b1; we2 = 1'b1;
               idx_in = IW'(2 * idx_ff + 1); d_in = d_ff + DW'(1);
               k_in = k_ff << 1; sz_in = sz_ff >> 1; split_in = 1'b1;
            end else begin
               we0 = 1'b1; wd0 = NODE_ALLOC;
               cnt_we = 1'b1;
               cnt_wd = (9'(cnt_ff[lvl]) + (split_ff ? 9'd1 : 9'd2)) > 9'd255 ?
                        8'd255 : 8'(cnt_ff[lvl] + (split_ff ? 8'd1 : 8'd2));
               status_in = STATUS_GRANTED;
               obase_in = 11'(32'(k_ff) * 32'(sz_ff));
               osize_in = 12'(sz_ff);
               state_in = ST_RESP;
            end
         end
         ST_WALK_RD: begin
            status_in = STATUS_INVALID;
            if (32'(base_ff) >= TOTAL_SIZE) state_in = ST_RESP;
            else state_in = ST_WALK_CHK;
         end
         ST_WALK_CHK: begin
            if (rd_ff == NODE_ALLOC) begin
               if (k_ff == SW'(base_ff)) begin
                  we0 = 1'b1; wd0 = NODE_FREE;
                  status_in = STATUS_FREED;
                  obase_in = 11'(k_ff); osize_in = 12'(sz_ff);
                  if (mode_ff == 1'b0) state_in = ST_MERGE_RD;
                  else if (cnt_ff[lvl] >= 8'd2) begin
                     cnt_we = 1'b1; cnt_wd = cnt_ff[lvl] - 8'd2;
                     state_in = ST_RESP;
                  end else begin
                     cnt_we = 1'b1; cnt_wd = '0;
                     xtra_in = (cnt_ff[lvl] == '0);
                     state_in = ST_MERGE_RD;
                  end
               end else state_in = ST_RESP;
            end else if (rd_ff != NODE_SPLIT || d_ff == DW'(DEPTHS - 1)) begin
               state_in = ST_RESP;
            end else begin
               d_in = d_ff + DW'(1); sz_in = sz_ff >> 1;
               if (SW'(base_ff) >= k_ff + (sz_ff >> 1)) begin
                  k_in = k_ff + (sz_ff >> 1); idx_in = IW'(2 * idx_ff + 2);
               end else idx_in = IW'(2 * idx_ff + 1);
               state_in = ST_WALK_RD;
            end
         end
         ST_MERGE_RD: state_in = ST_MERGE_CHK;
         ST_MERGE_CHK: begin
            if (idx_ff != '0 && rd_ff == NODE_FREE && bud_ff == NODE_FREE) begin
               we0 = 1'b1; wd0 = NODE_UNUSED;
               we1 = 1'b1; wa1 = buddy; wd1 = NODE_UNUSED;
               we2 = 1'b1; wa2 = parent; wd2 = NODE_FREE;
               if (mode_ff == 1'b0) begin
                  idx_in = parent; d_in = d_ff - DW'(1);
                  state_in = ST_MERGE_RD;
               end else if (xtra_ff) begin
                  xtra_in = 1'b0; idx_in = lvl_first; k_in = '0;
                  state_in = ST_XSCAN_RD;
               end else state_in = ST_RESP;
            end else if (xtra_ff) begin
               xtra_in = 1'b0; idx_in = lvl_first; k_in = '0;
               state_in = ST_XSCAN_RD;
            end else state_in = ST_RESP;
         end
         ST_XSCAN_RD: state_in = ST_XSCAN_CHK;
         ST_XSCAN_CHK: begin
            if (rd_ff == NODE_FREE) state_in = ST_MERGE_RD;
            else if (k_ff == SW'((1 << d_ff) - 1)) state_in = ST_RESP;
            else begin
               k_in = k_ff + SW'(1); idx_in = idx_ff + IW'(1);
               state_in = ST_XSCAN_RD;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      // root starts free: write it after reset, when no other memory write is made
      if (!vld_ff[0] && !we0 && !we1 && !we2) begin
         we0 = 1'b1; wa0 = '0; wd0 = NODE_FREE;
      end
   end
endmodule

// ----- rtl/lba_checker.sv -----
// Port-level checks of the lazy buddy allocator, bound to the top level.
module lba_assertions
   import lba_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_ready
);
   // hold a waiting result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");
   // take no request while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken with result pending");
   // accepted request stalls the input next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !csr_ready)
      else $error("ready during work");
   // failed result carries zero size
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == STATUS_NOSPACE || rsp_tdata[1:0] == STATUS_INVALID)
      |-> rsp_tdata[24:13] == '0)
      else $error("failure with nonzero size");
endmodule

bind lazy_buddy_allocator_top lba_assertions u_lba_assertions (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .csr_ready(csr_ready));

// ----- verif/lba_checker.sv -----
// Checker for the lazy buddy allocator: watches the channels, predicts each response word.
module lba_checker
   import lba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        req_tuser,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,
   output int          errors,
   output int          pending
);

   localparam int REGION = 2048;
   localparam int LEVELS = 7;
   localparam int NODES  = 127;

   typedef struct packed {
      logic [1:0]  status;
      logic [10:0] base;
      logic [11:0] size;
   } alloc_resp_type;

   logic [1:0]  tree [0:NODES-1];
   logic [7:0]  level_count [0:LEVELS-1];
   logic        lazy_mode;
   alloc_resp_type due_q [$];

   // Bump the counter of a level, saturating at full scale
   function automatic void count_bump(int depth, int amount);
      int lvl;
      int v;
      lvl = LEVELS - 1 - depth;
      v = level_count[lvl] + amount;
      level_count[lvl] = (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // Join a free node with its free buddy; return the parent, or -1
   function automatic int join_buddy(int idx);
      int buddy;
      int parent;
      if (idx == 0) return -1;
      buddy = idx[0] ? idx + 1 : idx - 1;
      if (tree[buddy] != NODE_FREE || tree[idx] != NODE_FREE) return -1;
      parent = (idx - 1) / 2;
      tree[parent] = NODE_FREE;
      tree[idx]    = NODE_UNUSED;
      tree[buddy]  = NODE_UNUSED;
      return parent;
   endfunction

   // Work out the response to one request word and update the tree
   function automatic alloc_resp_type allocator_step(logic op, logic [11:0] want,
                                                     logic [10:0] addr);
      alloc_resp_type r;
      int found;
      int fd;
      int fk;
      int sz;
      int idx;
      int d;
      int nb;
      int lvl;
      int c;
      int p;
      bit split;
      bit ok;
      r = '0;
      found = -1;
      fd = 0;
      fk = 0;
      if (op == OP_ALLOC) begin
         // smallest fitting level first, lowest address on ties
         for (d = LEVELS - 1; d >= 0 && found < 0; d--) begin
            if ((REGION >> d) < want) continue;
            for (int k = 0; k < (1 << d); k++) begin
               if (tree[(1 << d) - 1 + k] == NODE_FREE) begin
                  found = (1 << d) - 1 + k;
                  fd = d;
                  fk = k;
                  break;
               end
            end
         end
         if (found < 0) begin
            r.status = STATUS_NOSPACE;
         end else begin
            idx = found;
            sz = REGION >> fd;
            split = 0;
            while (fd + 1 < LEVELS && sz / 2 >= want) begin
               tree[idx] = NODE_SPLIT;
               tree[2 * idx + 1] = NODE_FREE;
               tree[2 * idx + 2] = NODE_FREE;
               idx = 2 * idx + 1;
               fd++;
               fk *= 2;
               sz /= 2;
               split = 1;
            end
            tree[idx] = NODE_ALLOC;
            count_bump(fd, split ? 1 : 2);
            r.status = STATUS_GRANTED;
            r.base = fk * sz;
            r.size = sz;
         end
      end else begin
         idx = 0;
         d = 0;
         nb = 0;
         sz = REGION;
         ok = 0;
         r.status = STATUS_INVALID;
         // walk down towards the named base
         forever begin
            if (tree[idx] == NODE_ALLOC) begin
               ok = (nb == addr);
               break;
            end
            if (tree[idx] != NODE_SPLIT || d + 1 >= LEVELS) break;
            sz /= 2;
            d++;
            if (addr >= nb + sz) begin
               nb += sz;
               idx = 2 * idx + 2;
            end else begin
               idx = 2 * idx + 1;
            end
         end
         if (ok) begin
            r.status = STATUS_FREED;
            r.base = nb;
            r.size = sz;
            tree[idx] = NODE_FREE;
            if (!lazy_mode) begin
               p = join_buddy(idx);
               while (p >= 0) p = join_buddy(p);
            end else begin
               lvl = LEVELS - 1 - d;
               c = level_count[lvl];
               if (c >= 2) begin
                  level_count[lvl] = c - 2;
               end else begin
                  level_count[lvl] = 0;
                  void'(join_buddy(idx));
                  // one extra merge on the lowest free block of this size
                  if (c == 0) begin
                     for (int k = 0; k < (1 << d); k++) begin
                        if (tree[(1 << d) - 1 + k] == NODE_FREE) begin
                           void'(join_buddy((1 << d) - 1 + k));
                           break;
                        end
                     end
                  end
               end
            end
         end
      end
      return r;
   endfunction

   assign pending = due_q.size();

   // Predict on each request word, compare on each response word
   always @(posedge clock) begin
      alloc_resp_type want_r;
      if (reset) begin
         for (int i = 0; i < NODES; i++) tree[i] = NODE_UNUSED;
         tree[0] = NODE_FREE;
         for (int i = 0; i < LEVELS; i++) level_count[i] = '0;
         lazy_mode = 1'b0;
         due_q.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) lazy_mode = csr_data;
         if (req_tvalid && req_tready)
            due_q.push_back(allocator_step(req_tuser, req_tdata[11:0], req_tdata[22:12]));
         if (rsp_tvalid && rsp_tready) begin
            if (due_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response word %h", rsp_tdata);
            end else begin
               want_r = due_q.pop_front();
               if (rsp_tdata[1:0] !== want_r.status || rsp_tdata[12:2] !== want_r.base ||
                   rsp_tdata[24:13] !== want_r.size) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp status %0d base %0d size %0d, got %0d %0d %0d",
                              want_r.status, want_r.base, want_r.size,
                              rsp_tdata[1:0], rsp_tdata[12:2], rsp_tdata[24:13]);
               end
            end
         end
      end
   end

endmodule

// ----- verif/tb_lazy_buddy_allocator_top.sv -----
// Testbench top for the lazy buddy allocator: stimulus, idling and verdict.
module tb_lazy_buddy_allocator_top;
   import lba_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic        req_tuser;   // operation
   logic [23:0] req_tdata;   // request_size[11:0], block_base[22:12]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // status[1:0], granted_base[12:2], granted_size[24:13]
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;
   int          errors;
   int          pending;
   int          rsp_hold;
   logic [10:0] held_bases [$];

   lazy_buddy_allocator_top dut (.*);

   lba_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Pick a gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Stall the response side at random; keep granted bases for later frees
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready && rsp_tdata[1:0] == STATUS_GRANTED)
            held_bases.push_back(rsp_tdata[12:2]);
         if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_hold <= pick_gap();
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_word(logic op, logic [11:0] want, logic [10:0] addr);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {1'b0, addr, want};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drain all responses, then write the mode register
   task automatic set_mode(logic m);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_words(int n);
      int r;
      int pick;
      logic [11:0] want;
      for (int i = 0; i < n; i++) begin
         if (held_bases.size() > 0 && $urandom_range(99) < 45) begin
            if ($urandom_range(99) < 80) begin
               pick = $urandom_range(held_bases.size() - 1);
               send_word(OP_FREE, 12'($urandom), held_bases[pick]);
               held_bases.delete(pick);
            end else begin
               send_word(OP_FREE, 12'($urandom), 11'($urandom));
            end
         end else begin
            r = $urandom_range(99);
            if (r < 60) want = $urandom_range(1, 64);
            else if (r < 85) want = $urandom_range(1, 512);
            else if (r < 95) want = $urandom_range(1, 2048);
            else if (r < 97) want = 12'd0;
            else want = $urandom_range(2049, 4095);
            send_word(OP_ALLOC, want, 11'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = OP_ALLOC;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_mode(1'b0);
      // Directed: whole region, no space, invalid frees, zero and oversize requests
      send_word(OP_ALLOC, 12'd2048, 11'h7FF);
      send_word(OP_ALLOC, 12'd1, 11'd0);
      send_word(OP_FREE, 12'hFFF, 11'd0);
      send_word(OP_FREE, 12'd0, 11'd0);
      send_word(OP_ALLOC, 12'd0, 11'd0);
      send_word(OP_ALLOC, 12'd4095, 11'd0);
      send_word(OP_ALLOC, 12'd32, 11'd0);
      send_word(OP_ALLOC, 12'd33, 11'd0);
      send_word(OP_ALLOC, 12'd1000, 11'd0);
      send_word(OP_FREE, 12'd0, 11'h7FF);
      send_word(OP_FREE, 12'd0, 11'd32);
      send_word(OP_FREE, 12'd0, 11'd64);
      send_word(OP_FREE, 12'd0, 11'd1024);
      send_word(OP_FREE, 12'd0, 11'd0);
      send_word(OP_FREE, 12'd0, 11'd0);
      set_mode(1'b1);
      // Lazy mode: counters decide skip, single merge or extra merge
      send_word(OP_ALLOC, 12'd32, 11'd0);
      send_word(OP_ALLOC, 12'd32, 11'd0);
      send_word(OP_FREE, 12'd0, 11'd0);
      send_word(OP_FREE, 12'd0, 11'd32);
      send_word(OP_FREE, 12'd0, 11'd0);
      send_word(OP_ALLOC, 12'd2048, 11'd0);
      set_mode(1'b0);
      held_bases.delete();
      random_words(430);
      set_mode(1'b1);
      random_words(450);
      set_mode(1'b0);
      random_words(50);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- lazy_buddy_allocator_top.f -----
rtl/lba_pkg.sv
rtl/lazy_buddy_allocator_top.sv
rtl/lba_checker.sv
verif/lba_checker.sv
verif/tb_lazy_buddy_allocator_top.sv
